// ===== rtl/gdba_pkg.sv =====
// ----------------------------------------------------------------------------
// gdba_pkg
// Shared types and constants for the gradient direction band average core.
// ----------------------------------------------------------------------------
package gdba_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 11'd1024;

   // band codes
   localparam logic [1:0] BAND_NONE    = 2'd0;
   localparam logic [1:0] BAND_ACUTE   = 2'd1;
   localparam logic [1:0] BAND_OBTUSE  = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

   // atan unit
   localparam int CORDIC_STEPS = 40;
   localparam int XY_W         = 52;
   localparam int Z_W          = 49;
   localparam int Q_W          = 15;
   localparam int RND_W        = 56;
   localparam int ANGLE_W      = 16;
   localparam logic [63:0] DEG_PER_RAD_E12 = 64'd57295779513082;
   localparam logic [63:0] ANG_E12         = 64'd1000000000000;
   localparam logic [ANGLE_W-1:0] OBTUSE_BASE = 16'd23040;

   typedef struct packed {
      logic [1:0]       band;
      logic [PIX_W-1:0] num;
      logic [PIX_W-1:0] den;
      logic             last;
   } job_type;

   // per-step rotation angle in 1e-12 degree
   function automatic logic [Z_W-2:0] step_angle(input logic [5:0] i);
      logic [63:0] t;
      t = 64'd0;
      case (i)
         6'd0:  t = 64'd45000000000000;
         6'd1:  t = 64'd26565051177078;
         6'd2:  t = 64'd14036243467926;
         6'd3:  t = 64'd7125016348902;
         6'd4:  t = 64'd3576334374997;
         6'd5:  t = 64'd1789910608246;
         6'd6:  t = 64'd895173710211;
         6'd7:  t = 64'd447614170861;
         6'd8:  t = 64'd223810500369;
         6'd9:  t = 64'd111905677066;
         6'd10: t = 64'd55952891894;
         6'd11: t = 64'd27976452617;
         6'd12: t = 64'd13988227142;
         6'd13: t = 64'd6994113675;
         6'd14: t = 64'd3497056851;
         6'd15: t = 64'd1748528427;
         6'd16: t = 64'd874264214;
         6'd17: t = 64'd437132107;
         default: t = (DEG_PER_RAD_E12 + (64'd1 << (i - 6'd1))) >> i;
      endcase
      return t[Z_W-2:0];
   endfunction

endpackage

// ===== rtl/gradient_direction_band_average_core.sv =====
// ----------------------------------------------------------------------------
// gradient_direction_band_average_core
// Per-frame mean gradient angle of the (0,45) and (90,135) degree bands.
// ----------------------------------------------------------------------------
// Pixels enter on req_* in raster order, one beat per pixel; frame size comes
// from the csr_* write port (index 0 width, 1 height), written while idle.
// One rsp_* beat leaves per frame, after the frame's last pixel: band means
// in 1/256 degree, counts, and a valid flag per band (mean 0 when empty).
// A pixel that lands in a band goes through the shared atan unit (pop,
// 40 rotations, 3 rounding steps, accumulate); others queue no job unless last.
// A four-entry job queue lets the front keep taking pixels at one per cycle
// while the atan unit works; req_stall rises when the queue entries plus
// the pixel being classified reach the depth. After the frame's last job a
// prepare step and a 16-step divide run; the result is held in a register
// while rsp_stall is high; next-frame pixels are taken until the queue fills.
// Reset clears counters, sums and queue; frame size returns to 1024 x 1024.
// ----------------------------------------------------------------------------
module gradient_direction_band_average_core #(
   parameter int MAX_WIDTH  = gdba_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gdba_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [gdba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gdba_pkg::CFG_W-1:0]      csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [gdba_pkg::PIX_W-1:0]      req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [13:0]                     rsp_acute_avg,
   output logic [15:0]                     rsp_obtuse_avg,
   output logic [19:0]                     rsp_acute_count,
   output logic [19:0]                     rsp_obtuse_count,
   output logic                            rsp_acute_valid,
   output logic                            rsp_obtuse_valid
);
   import gdba_pkg::*;

   logic [CFG_W-1:0] frame_width_ff, frame_height_ff;
   logic             job_valid, q_valid, q_pop, atan_start, atan_done;
   job_type          job, q_job;
   logic [QC_W-1:0]  q_count;
   logic [PIX_W-1:0] atan_num, atan_den;
   logic [Q_W-1:0]   atan_angle;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_DIM_RESET;
         frame_height_ff <= CFG_DIM_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   gdba_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel    (req_pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_count      (q_count),
      .job_valid    (job_valid),
      .job          (job)
   );

   gdba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_job),
      .count     (q_count)
   );

   gdba_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (atan_start),
      .num   (atan_num),
      .den   (atan_den),
      .done  (atan_done),
      .angle (atan_angle)
   );

   gdba_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_valid),
      .job              (q_job),
      .job_pop          (q_pop),
      .atan_start       (atan_start),
      .atan_num         (atan_num),
      .atan_den         (atan_den),
      .atan_done        (atan_done),
      .atan_angle       (atan_angle),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_acute_avg    (rsp_acute_avg),
      .rsp_obtuse_avg   (rsp_obtuse_avg),
      .rsp_acute_count  (rsp_acute_count),
      .rsp_obtuse_count (rsp_obtuse_count),
      .rsp_acute_valid  (rsp_acute_valid),
      .rsp_obtuse_valid (rsp_obtuse_valid)
   );

endmodule

// ===== rtl/gdba_queue.sv =====
// ----------------------------------------------------------------------------
// gdba_queue
// Small job queue between the pixel front end and the angle back end.
// ----------------------------------------------------------------------------
module gdba_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gdba_pkg::job_type push_job,
   input  logic             pop,
   output logic             pop_valid,
   output gdba_pkg::job_type pop_job,
   output logic [gdba_pkg::QC_W-1:0] count
);
   import gdba_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [QC_W-1:0]  cnt_ff, cnt_in;
   logic             do_pop;

   assign do_pop    = pop && (cnt_ff != '0);
   assign pop_valid = (cnt_ff != '0);
   assign pop_job   = mem_ff[rptr_ff];
   assign count     = cnt_ff;

   always_comb begin
      wptr_in = push ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in = do_pop ? rptr_ff + PW'(1) : rptr_ff;
      cnt_in  = cnt_ff + QC_W'(push) - QC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/gdba_front.sv =====
// ----------------------------------------------------------------------------
// gdba_front
// Raster counters, line memory and gradient band classification.
// ----------------------------------------------------------------------------
module gdba_front #(
   parameter int MAX_WIDTH  = gdba_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gdba_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [gdba_pkg::PIX_W-1:0]  req_pixel,
   input  logic [gdba_pkg::CFG_W-1:0]  frame_width,
   input  logic [gdba_pkg::CFG_W-1:0]  frame_height,
   input  logic [gdba_pkg::QC_W-1:0]   q_count,
   output logic                        job_valid,
   output gdba_pkg::job_type           job
);
   import gdba_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DIM_W = 14;

   logic [PIX_W-1:0] line_mem [MAX_WIDTH];

   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic             last_col, last_row, accept;

   logic             s1_valid_ff, s1_last_ff, s1_col_nz_ff, s1_row_nz_ff;
   logic [PIX_W-1:0] s1_pixel_ff, rd_ff, prev_old_ff, prev_pix_ff;

   logic signed [PIX_W:0] dx, dy, ndx;
   logic [1:0]       band;

   always_comb begin
      w_eff = DIM_W'(frame_width);
      if (w_eff < DIM_W'(2)) w_eff = DIM_W'(2);
      else if (w_eff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      h_eff = DIM_W'(frame_height);
      if (h_eff < DIM_W'(2)) h_eff = DIM_W'(2);
      else if (h_eff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
   end

   assign last_col  = DIM_W'(col_ff) >= (w_eff - DIM_W'(1));
   assign last_row  = DIM_W'(row_ff) >= (h_eff - DIM_W'(1));
   assign req_stall = ((QC_W+1)'(q_count) + (QC_W+1)'(s1_valid_ff))
                      >= (QC_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (!last_col) begin
            col_in = col_ff + CW'(1);
         end else begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
      end
   end

   // read-before-write: rd_ff holds the previous row's pixel at this column
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff            <= line_mem[col_ff];
         line_mem[col_ff] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff  <= req_pixel;
         s1_last_ff   <= last_col && last_row;
         s1_col_nz_ff <= (col_ff != '0);
         s1_row_nz_ff <= (row_ff != '0);
      end
      if (s1_valid_ff) begin
         prev_old_ff <= rd_ff;
         prev_pix_ff <= s1_pixel_ff;
      end
   end

   // judge the pixel one up and one left: p, its right neighbor, its lower one
   always_comb begin
      dx   = $signed({1'b0, prev_old_ff}) - $signed({1'b0, rd_ff});
      dy   = $signed({1'b0, prev_old_ff}) - $signed({1'b0, prev_pix_ff});
      ndx  = -dx;
      band = BAND_NONE;
      if (s1_col_nz_ff && s1_row_nz_ff && prev_old_ff != '0 && dy > 0) begin
         if (dx > 0 && dy < dx) band = BAND_ACUTE;
         else if (dx < 0 && dy > ndx) band = BAND_OBTUSE;
      end
      job.band = band;
      job.last = s1_last_ff;
      if (band == BAND_OBTUSE) begin
         job.num = ndx[PIX_W-1:0];
         job.den = dy[PIX_W-1:0];
      end else begin
         job.num = dy[PIX_W-1:0];
         job.den = dx[PIX_W-1:0];
      end
      job_valid = s1_valid_ff && (band != BAND_NONE || s1_last_ff);
   end

endmodule

// ===== rtl/gdba_cordic.sv =====
// ----------------------------------------------------------------------------
// gdba_cordic
// Iterative vectoring atan(num/den), one rotation per cycle, then a
// reciprocal-multiply rounding to 1/256 degree (scale, estimate, correct).
// ----------------------------------------------------------------------------
module gdba_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [gdba_pkg::PIX_W-1:0]    num,
   input  logic [gdba_pkg::PIX_W-1:0]    den,
   output logic                          done,
   output logic [gdba_pkg::Q_W-1:0]      angle
);
   import gdba_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROT  = 2'd1;
   localparam logic [1:0] ST_RND  = 2'd2;
   localparam logic [RND_W-1:0] RND_HALF = RND_W'(ANG_E12 / 64'd2);
   // 1e12 = 2^12 * 5^12; floor(2^42 / 5^12)
   localparam logic [27:0] FIVE_12 = 28'd244140625;
   localparam logic [14:0] RCP_K   = 15'd18014;

   logic [1:0]              st_ff, st_in;
   logic [5:0]              i_ff, i_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in, xs, ys, ymag;
   logic signed [Z_W-1:0]   z_ff, z_in, ang;
   logic [RND_W-1:0]        rem_ff, rem_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic [Z_W-2:0]          zc;
   logic [46:0]             prod_est;
   logic [43:0]             prod_chk;
   logic                    done_in;

   always_comb begin
      xs   = x_ff >>> i_ff;
      ymag = -y_ff;
      ys   = y_ff[XY_W-1] ? -(ymag >>> i_ff) : (y_ff >>> i_ff);
      ang  = $signed({1'b0, step_angle(i_ff)});
      zc   = z_ff[Z_W-1] ? '0 : z_ff[Z_W-2:0];
      prod_est = 47'(rem_ff[41:10]) * 47'(RCP_K);
      prod_chk = 44'(q_ff + Q_W'(1)) * 44'(FIVE_12);

      st_in   = st_ff;
      i_in    = i_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      done_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               x_in  = XY_W'({den, 40'd0});
               y_in  = XY_W'({num, 40'd0});
               z_in  = '0;
               i_in  = '0;
               st_in = ST_ROT;
            end
         end
         ST_ROT: begin
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end
            i_in = i_ff + 6'd1;
            if (i_ff == 6'(CORDIC_STEPS - 1)) begin
               st_in = ST_RND;
            end
         end
         ST_RND: begin
            if (i_ff == 6'(CORDIC_STEPS)) begin
               // scale to 1/256 degree, add the half, drop the 2^12 factor
               rem_in = (RND_W'({zc, 8'd0}) + RND_HALF) >> 12;
               i_in   = i_ff + 6'd1;
            end else if (i_ff == 6'(CORDIC_STEPS + 1)) begin
               // quotient by 5^12 estimate, low by at most one
               q_in = prod_est[46:32];
               i_in = i_ff + 6'd1;
            end else begin
               if (RND_W'(prod_chk) <= rem_ff) begin
                  q_in = q_ff + Q_W'(1);
               end
               st_in   = ST_IDLE;
               done_in = 1'b1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         done  <= 1'b0;
      end else begin
         st_ff <= st_in;
         done  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign angle = q_ff;

endmodule

// ===== rtl/gdba_back.sv =====
// ----------------------------------------------------------------------------
// gdba_back
// Runs queued jobs through the atan unit, accumulates per band and at
// frame end divides sums by counts into the result register.
// ----------------------------------------------------------------------------
module gdba_back #(
   parameter int MAX_WIDTH  = gdba_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gdba_pkg::DEF_MAX_HEIGHT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  gdba_pkg::job_type           job,
   output logic                        job_pop,
   output logic                        atan_start,
   output logic [gdba_pkg::PIX_W-1:0]  atan_num,
   output logic [gdba_pkg::PIX_W-1:0]  atan_den,
   input  logic                        atan_done,
   input  logic [gdba_pkg::Q_W-1:0]    atan_angle,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [13:0]                 rsp_acute_avg,
   output logic [15:0]                 rsp_obtuse_avg,
   output logic [19:0]                 rsp_acute_count,
   output logic [19:0]                 rsp_obtuse_count,
   output logic                        rsp_acute_valid,
   output logic                        rsp_obtuse_valid
);
   import gdba_pkg::*;

   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUM_W = CNT_W + ANGLE_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ATAN = 3'd1;
   localparam logic [2:0] ST_PREP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]          st_ff, st_in;
   logic [1:0]          band_ff;
   logic                last_ff;
   logic [SUM_W-1:0]    asum_ff, asum_in, osum_ff, osum_in;
   logic [CNT_W-1:0]    acnt_ff, acnt_in, ocnt_ff, ocnt_in;
   logic [SUM_W-1:0]    arem_ff, arem_in, orem_ff, orem_in;
   logic [SUM_W-1:0]    aden_ff, aden_in, oden_ff, oden_in;
   logic [ANGLE_W-1:0]  aq_ff, aq_in, oq_ff, oq_in, ang;
   logic [3:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in, load_out;

   assign atan_num   = job.num;
   assign atan_den   = job.den;
   assign ang        = (band_ff == BAND_OBTUSE) ? OBTUSE_BASE + ANGLE_W'(atan_angle)
                                                : ANGLE_W'(atan_angle);

   always_comb begin
      st_in      = st_ff;
      asum_in    = asum_ff;
      osum_in    = osum_ff;
      acnt_in    = acnt_ff;
      ocnt_in    = ocnt_ff;
      arem_in    = arem_ff;
      orem_in    = orem_ff;
      aden_in    = aden_ff;
      oden_in    = oden_ff;
      aq_in      = aq_ff;
      oq_in      = oq_ff;
      step_in    = step_ff;
      job_pop    = 1'b0;
      atan_start = 1'b0;
      load_out   = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               if (job.band != BAND_NONE) begin
                  atan_start = 1'b1;
                  st_in      = ST_ATAN;
               end else begin
                  st_in = ST_PREP;
               end
            end
         end
         ST_ATAN: begin
            if (atan_done) begin
               if (band_ff == BAND_ACUTE) begin
                  asum_in = asum_ff + SUM_W'(ang);
                  acnt_in = acnt_ff + CNT_W'(1);
               end else begin
                  osum_in = osum_ff + SUM_W'(ang);
                  ocnt_in = ocnt_ff + CNT_W'(1);
               end
               st_in = last_ff ? ST_PREP : ST_IDLE;
            end
         end
         ST_PREP: begin
            arem_in = asum_ff;
            orem_in = osum_ff;
            aden_in = {acnt_ff, {(ANGLE_W-1){1'b0}}, 1'b0} >> 1;
            oden_in = {ocnt_ff, {(ANGLE_W-1){1'b0}}, 1'b0} >> 1;
            aq_in   = '0;
            oq_in   = '0;
            step_in = '0;
            st_in   = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per band per cycle
            if (arem_ff >= aden_ff) begin
               arem_in = arem_ff - aden_ff;
               aq_in   = {aq_ff[ANGLE_W-2:0], 1'b1};
            end else begin
               aq_in   = {aq_ff[ANGLE_W-2:0], 1'b0};
            end
            if (orem_ff >= oden_ff) begin
               orem_in = orem_ff - oden_ff;
               oq_in   = {oq_ff[ANGLE_W-2:0], 1'b1};
            end else begin
               oq_in   = {oq_ff[ANGLE_W-2:0], 1'b0};
            end
            aden_in = aden_ff >> 1;
            oden_in = oden_ff >> 1;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(ANGLE_W - 1)) begin
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               load_out = 1'b1;
               asum_in  = '0;
               osum_in  = '0;
               acnt_in  = '0;
               ocnt_in  = '0;
               st_in    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         asum_ff      <= '0;
         osum_ff      <= '0;
         acnt_ff      <= '0;
         ocnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         asum_ff      <= asum_in;
         osum_ff      <= osum_in;
         acnt_ff      <= acnt_in;
         ocnt_ff      <= ocnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arem_ff <= arem_in;
      orem_ff <= orem_in;
      aden_ff <= aden_in;
      oden_ff <= oden_in;
      aq_ff   <= aq_in;
      oq_ff   <= oq_in;
      step_ff <= step_in;
      if (job_pop) begin
         band_ff <= job.band;
         last_ff <= job.last;
      end
      if (load_out) begin
         rsp_acute_avg    <= (acnt_ff != '0) ? aq_ff[13:0] : 14'd0;
         rsp_obtuse_avg   <= (ocnt_ff != '0) ? oq_ff : 16'd0;
         rsp_acute_count  <= 20'(acnt_ff);
         rsp_obtuse_count <= 20'(ocnt_ff);
         rsp_acute_valid  <= (acnt_ff != '0);
         rsp_obtuse_valid <= (ocnt_ff != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
